FILE: rtl/core/slot_lifecycle_tracker_assert.svh
// ----------------------------------------------------------------------------
// slot_lifecycle_tracker_assert.svh
// Assertion macros for the slot lifecycle tracker.
// ----------------------------------------------------------------------------
`ifndef SLOT_LIFECYCLE_TRACKER_ASSERT_SVH
`define SLOT_LIFECYCLE_TRACKER_ASSERT_SVH

`ifndef SYNTH
`define SLT_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("slot_lifecycle_tracker: check failed");
`define SLT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("slot_lifecycle_tracker: check failed");
`else
`define SLT_ASSERT_NOW(label, cond)
`define SLT_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants and types of the slot lifecycle tracker.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OWNER_W    = 32;
    localparam int CMD_W      = 3;
    localparam int INDEX_W    = 3;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 16;

    typedef logic [1:0]         phase_t;
    typedef logic [OWNER_W-1:0] owner_t;
    typedef logic [CMD_W-1:0]   cmd_t;

    typedef logic [SLOTS-1:0][1:0]         phase_arr_t;
    typedef logic [SLOTS-1:0][OWNER_W-1:0] owner_arr_t;

    localparam phase_t PH_IDLE     = 2'd0;
    localparam phase_t PH_READY    = 2'd1;
    localparam phase_t PH_PENDING  = 2'd2;
    localparam phase_t PH_FINISHED = 2'd3;

    localparam cmd_t CMD_QUERY      = 3'd0;
    localparam cmd_t CMD_CLEAR      = 3'd1;
    localparam cmd_t CMD_TO_READY   = 3'd2;
    localparam cmd_t CMD_TO_PENDING = 3'd3;
    localparam cmd_t CMD_TO_FINISH  = 3'd4;
    localparam cmd_t CMD_TO_IDLE    = 3'd5;

    typedef struct packed {
        logic               owner_pending;
        logic               any_finished;
        logic               any_pending;
        logic               any_ready;
        logic               any_idle;
        logic [INDEX_W-1:0] slot_index;
        logic               done_res;
    } result_t;

endpackage

FILE: rtl/core/slot_lifecycle_tracker.sv
// ----------------------------------------------------------------------------
// slot_lifecycle_tracker
// Table of slots with lifecycle phase and owner; one command per item.
// Pipeline: input reg, then result reg.
// Throughput: one item per cycle while m_tready does not stall the output; the table updates in the result stage.
// Reset: synchronous active-low; all slots idle with owner zero, pipeline empty.
// ----------------------------------------------------------------------------
`include "slot_lifecycle_tracker_assert.svh"

module slot_lifecycle_tracker
    import slt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // command[2:0], owner_id[34:3], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // done_res[0], slot_index[3:1], any_idle[4],
                                        // any_ready[5], any_pending[6],
                                        // any_finished[7], owner_pending[8], zero pad
);

    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    owner_t     in_owner_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    phase_arr_t phase_reg;
    owner_arr_t owner_reg;
    phase_arr_t phase_next;
    owner_arr_t owner_next;
    result_t    res_next;
    logic       adv;
    logic       fire;

    assign adv      = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    slt_eval u_eval (
        .phase      (phase_reg),
        .owner      (owner_reg),
        .cmd        (in_cmd_reg),
        .owner_id   (in_owner_reg),
        .phase_next (phase_next),
        .owner_next (owner_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= s_tdata[CMD_W-1:0];
            in_owner_reg <= s_tdata[CMD_W +: OWNER_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            owner_reg     <= '0;
        end else begin
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                phase_reg <= phase_next;
                owner_reg <= owner_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_res_reg};

    `SLT_ASSERT_NOW(a_idx_zero_on_miss, !out_valid_reg || out_res_reg.done_res || (out_res_reg.slot_index == '0))
    `SLT_ASSERT_NEXT(a_clear_empties, fire && (in_cmd_reg == CMD_CLEAR), (phase_reg == '0) && (owner_reg == '0))
    `SLT_ASSERT_NEXT(a_stall_holds, in_valid_reg && !adv, in_valid_reg && $stable(in_cmd_reg) && $stable(phase_reg))

endmodule

FILE: rtl/core/slt_eval.sv
// ----------------------------------------------------------------------------
// slt_eval
// Slot match, priority select, next table state and status flags.
// ----------------------------------------------------------------------------
module slt_eval
    import slt_pkg::*;
(
    input  phase_arr_t phase,
    input  owner_arr_t owner,
    input  cmd_t       cmd,
    input  owner_t     owner_id,
    output phase_arr_t phase_next,
    output owner_arr_t owner_next,
    output result_t    res
);

    logic [SLOTS-1:0]      eq;
    logic [SLOTS-1:0]      oz;
    logic [SLOTS-1:0]      match;
    logic [SLOTS-1:0]      neq;
    logic [SLOTS-1:0]      noz;
    logic                  idz;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] sel;
    logic [INDEX_W-1:0]    sel_out;

    assign idz = (owner_id == '0);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            eq[i] = (owner[i] == owner_id);
            oz[i] = (owner[i] == '0);
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            unique case (cmd)
                CMD_TO_READY:   match[i] = (phase[i] == PH_IDLE) && oz[i];
                CMD_TO_PENDING: match[i] = (phase[i] == PH_READY) && oz[i];
                CMD_TO_FINISH:  match[i] = (phase[i] == PH_PENDING) && eq[i];
                CMD_TO_IDLE:    match[i] = (phase[i] == PH_FINISHED) && eq[i];
                default:        match[i] = 1'b0;
            endcase
        end
    end

    // lowest index wins
    always_comb begin
        hit     = 1'b0;
        sel     = '0;
        sel_out = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                sel     = SLOT_IDX_W'(i);
                sel_out = INDEX_W'(i);
            end
        end
    end

    always_comb begin
        phase_next = phase;
        owner_next = owner;
        neq        = eq;
        noz        = oz;
        if (cmd == CMD_CLEAR) begin
            phase_next = '0;
            owner_next = '0;
            neq        = {SLOTS{idz}};
            noz        = '1;
        end else if (hit) begin
            unique case (cmd)
                CMD_TO_READY: begin
                    phase_next[sel] = PH_READY;
                end
                CMD_TO_PENDING: begin
                    phase_next[sel] = PH_PENDING;
                    owner_next[sel] = owner_id;
                    neq[sel]        = 1'b1;
                    noz[sel]        = idz;
                end
                CMD_TO_FINISH: begin
                    phase_next[sel] = PH_FINISHED;
                end
                CMD_TO_IDLE: begin
                    phase_next[sel] = PH_IDLE;
                    owner_next[sel] = '0;
                    neq[sel]        = idz;
                    noz[sel]        = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res               = '0;
        res.done_res      = hit || (cmd == CMD_CLEAR);
        res.slot_index    = hit ? sel_out : '0;
        for (int i = 0; i < SLOTS; i++) begin
            if ((phase_next[i] == PH_IDLE) && noz[i])      res.any_idle      = 1'b1;
            if ((phase_next[i] == PH_READY) && noz[i])     res.any_ready     = 1'b1;
            if ((phase_next[i] == PH_PENDING) && !noz[i])  res.any_pending   = 1'b1;
            if ((phase_next[i] == PH_FINISHED) && !noz[i]) res.any_finished  = 1'b1;
            if ((phase_next[i] == PH_PENDING) && neq[i])   res.owner_pending = 1'b1;
        end
    end

endmodule
